/* sv/sfr_pkg.sv */
// Shared types and constants for the sync frame receiver.
// Used by sfr_front, sfr_queue, sfr_back and sync_frame_receiver_with_checksum.
package sfr_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int SUM_W       = 20;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SECOND = 2'd1,
    PH_GATHER = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_INFO     = 2'd0,
    KIND_MEAS     = 2'd1,
    KIND_CSUM_ERR = 2'd2,
    KIND_UNKNOWN  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_SYNC_FIRST     = 3'd0,
    REG_SYNC_SECOND    = 3'd1,
    REG_INFO_TAG       = 3'd2,
    REG_MEASURE_TAG    = 3'd3,
    REG_SUPPRESS_EMPTY = 3'd4
  } reg_index_t;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'h61;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h01;
  localparam logic [15:0] INFO_TAG_RST    = 16'hDA7A;
  localparam logic [15:0] MEASURE_TAG_RST = 16'hFEED;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] info_tag;
    logic [15:0] measure_tag;
    logic        suppress_empty;
  } cfg_t;

  // One gathered frame, ready for checking and classification.
  typedef struct packed {
    logic [SUM_W-1:0] word_sum;
    logic [15:0]      tag;
    logic [31:0]      w1;
    logic [31:0]      w2;
    logic [15:0]      wall;
  } frame_t;

endpackage

/* sv/sfr_front.sv */
// Front end: sync hunt, frame byte capture and running word sum.
// Depends on sfr_pkg; pushes one frame_t per complete frame.
module sfr_front (
  input  logic          clk,
  input  logic          rst,
  input  sfr_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    rx_byte,
  output logic          push,
  input  logic          push_ready,
  output sfr_pkg::frame_t push_frame
);
  import sfr_pkg::*;

  phase_t           phase, phase_next;
  logic [3:0]       byte_count, byte_count_next;
  logic [SUM_W-1:0] word_sum, word_sum_next;
  logic [7:0]       frame_store [FRAME_BYTES];
  logic             store_en;
  logic [3:0]       store_idx;
  logic             accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_count <= 4'd0;
      word_sum   <= '0;
    end else begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      word_sum   <= word_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      frame_store[store_idx] <= rx_byte;
    end
  end

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    word_sum_next   = word_sum;
    store_en        = 1'b0;
    store_idx       = byte_count;
    push            = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_SECOND: begin
          if (rx_byte == cfg.sync_second) begin
            store_en        = 1'b1;
            store_idx       = 4'd1;
            word_sum_next   = word_sum + {4'd0, rx_byte, 8'd0};
            byte_count_next = 4'd2;
            phase_next      = PH_GATHER;
          end else begin
            byte_count_next = 4'd0;
            phase_next      = PH_HUNT;
          end
        end
        PH_GATHER: begin
          store_en = 1'b1;
          if (byte_count[0]) begin
            word_sum_next = word_sum + {4'd0, rx_byte, 8'd0};
          end else begin
            word_sum_next = word_sum + {12'd0, rx_byte};
          end
          if (byte_count == 4'(FRAME_BYTES - 1)) begin
            push            = 1'b1;
            byte_count_next = 4'd0;
            phase_next      = PH_HUNT;
          end else begin
            byte_count_next = byte_count + 4'd1;
          end
        end
        default: begin
          phase_next = PH_HUNT;
          if (rx_byte == cfg.sync_first) begin
            store_en        = 1'b1;
            store_idx       = 4'd0;
            word_sum_next   = {12'd0, rx_byte};
            byte_count_next = 4'd1;
            phase_next      = PH_SECOND;
          end
        end
      endcase
    end
  end

  // Bytes 2..13 are already stored when the last byte arrives.
  always_comb begin
    push_frame.word_sum = word_sum_next;
    push_frame.tag      = {frame_store[2], frame_store[3]};
    push_frame.w1       = {frame_store[7], frame_store[6], frame_store[5], frame_store[4]};
    push_frame.w2       = {frame_store[11], frame_store[10], frame_store[9], frame_store[8]};
    push_frame.wall     = {frame_store[13], frame_store[12]};
  end

endmodule

/* sv/sfr_queue.sv */
// Two-entry frame queue between front end and back end.
// Depends on sfr_pkg for frame_t.
module sfr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            push_ready,
  input  sfr_pkg::frame_t push_frame,
  output logic            head_valid,
  input  logic            pop,
  output sfr_pkg::frame_t head_frame
);
  import sfr_pkg::*;

  frame_t     entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = !count[1];
  assign head_valid = count != 2'd0;
  assign head_frame = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

endmodule

/* sv/sfr_back.sv */
// Back end: checksum fold and test, header classification, empty-measurement
// drop and the output register. Depends on sfr_pkg.
module sfr_back (
  input  logic                clk,
  input  logic                rst,
  input  sfr_pkg::cfg_t       cfg,
  input  logic                head_valid,
  input  sfr_pkg::frame_t     head_frame,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          frame_kind,
  output logic [31:0]         first_word,
  output logic [31:0]         second_word,
  output logic signed [15:0]  wall_distance,
  output logic [15:0]         check_value
);
  import sfr_pkg::*;

  logic [16:0] folded;
  logic [15:0] check;
  logic        drop;
  logic        load;
  kind_t       kind, kind_reg;
  logic [31:0] w1_sel, w2_sel;
  logic [15:0] wall_sel, check_sel;

  assign folded = {1'b0, head_frame.word_sum[15:0]} + {13'd0, head_frame.word_sum[19:16]};
  assign check  = ~folded[15:0];

  always_comb begin
    kind      = KIND_UNKNOWN;
    w1_sel    = '0;
    w2_sel    = '0;
    wall_sel  = '0;
    check_sel = '0;
    drop      = 1'b0;
    if (check != 16'd0) begin
      kind      = KIND_CSUM_ERR;
      check_sel = check;
    end else if (head_frame.tag == cfg.info_tag) begin
      kind   = KIND_INFO;
      w1_sel = head_frame.w1;
    end else if (head_frame.tag == cfg.measure_tag) begin
      kind     = KIND_MEAS;
      w1_sel   = head_frame.w1;
      w2_sel   = head_frame.w2;
      wall_sel = head_frame.wall;
      drop     = cfg.suppress_empty && (head_frame.w1[30:0] == 31'd0)
                 && (head_frame.w2[30:0] == 31'd0) && (head_frame.wall == 16'd0);
    end
  end

  assign pop  = head_valid && (!out_valid || out_ready);
  assign load = pop && !drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_reg      <= kind;
      first_word    <= w1_sel;
      second_word   <= w2_sel;
      wall_distance <= wall_sel;
      check_value   <= check_sel;
    end
  end

  assign frame_kind = kind_reg;

endmodule

/* sv/sync_frame_receiver_with_checksum.sv */
// Sync frame receiver: takes one received byte per transaction, finds
// sync_first followed at once by sync_second, gathers a 16-byte frame and
// tests its folded 16-bit ones-complement word sum. Bytes are accepted one
// per cycle; in_ready drops only when the two-entry frame queue is full,
// which needs the result port to be held back across two frames. A result
// passes through a queue slot and then the output register after the last
// frame byte; empty measurements are consumed without a result.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
module sync_frame_receiver_with_checksum (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         frame_kind,
  output logic [31:0]        first_word,
  output logic [31:0]        second_word,
  output logic signed [15:0] wall_distance,
  output logic [15:0]        check_value
);
  import sfr_pkg::*;

  cfg_t   cfg;
  logic   q_push, q_push_ready, q_valid, q_pop;
  frame_t q_in, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first     <= SYNC_FIRST_RST;
      cfg.sync_second    <= SYNC_SECOND_RST;
      cfg.info_tag       <= INFO_TAG_RST;
      cfg.measure_tag    <= MEASURE_TAG_RST;
      cfg.suppress_empty <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:     cfg.sync_first     <= cfg_data[7:0];
        REG_SYNC_SECOND:    cfg.sync_second    <= cfg_data[7:0];
        REG_INFO_TAG:       cfg.info_tag       <= cfg_data;
        REG_MEASURE_TAG:    cfg.measure_tag    <= cfg_data;
        REG_SUPPRESS_EMPTY: cfg.suppress_empty <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_frame (q_in)
  );

  sfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_frame (q_in),
    .head_valid (q_valid),
    .pop        (q_pop),
    .head_frame (q_head)
  );

  sfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head_valid    (q_valid),
    .head_frame    (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_kind    (frame_kind),
    .first_word    (first_word),
    .second_word   (second_word),
    .wall_distance (wall_distance),
    .check_value   (check_value)
  );

  a_back_drains: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !out_valid) |-> q_pop)
    else $error("back end idle with a queued frame");

  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (in_valid && in_ready))
    else $error("frame pushed without a byte transaction");

  a_check_matches_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((frame_kind == KIND_CSUM_ERR) == (check_value != 16'd0)))
    else $error("check_value disagrees with frame_kind");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench for sync_frame_receiver_with_checksum: sends byte transactions with random
// idles and result stalls, predicts each frame result and checks it field by field.
// Depends on sfr_pkg and the receiver RTL.
module tb;
  import sfr_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int TOTAL_BYTES  = 1750;

  typedef enum {
    SH_INFO, SH_MEAS, SH_MAX, SH_EMPTY, SH_SIGN_ONLY, SH_UNKNOWN,
    SH_BAD_SUM, SH_BROKEN_SYNC, SH_RETRY_TRAP, SH_NOISE
  } shape_t;

  typedef logic [15:0][7:0] frame_bytes_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [15:0] wall;
    logic [15:0] chk;
  } frame_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = REG_SYNC_FIRST;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         frame_kind;
  logic [31:0]        first_word;
  logic [31:0]        second_word;
  logic signed [15:0] wall_distance;
  logic [15:0]        check_value;

  // predictor copy of the registers and the receive state
  logic [7:0]  cur_sync_first  = SYNC_FIRST_RST;
  logic [7:0]  cur_sync_second = SYNC_SECOND_RST;
  logic [15:0] cur_info_tag    = INFO_TAG_RST;
  logic [15:0] cur_measure_tag = MEASURE_TAG_RST;
  logic        cur_suppress    = 1'b1;
  phase_t      rx_phase = PH_HUNT;
  logic [3:0]  rx_count = '0;
  logic [7:0]  rx_store [FRAME_BYTES];
  logic [SUM_W-1:0] rx_sum = '0;

  frame_result_t results_due[$];
  int mismatches   = 0;
  int bytes_sent   = 0;
  int quiet_cycles = 0;
  int in_idle_pct  = 11;
  int out_idle_pct = 11;
  logic hold_results = 1'b0;

  sync_frame_receiver_with_checksum dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .frame_kind(frame_kind),
    .first_word(first_word), .second_word(second_word), .wall_distance(wall_distance),
    .check_value(check_value)
  );

  always #5 clk = ~clk;

  function automatic void close_frame();
    logic [16:0] folded;
    logic [15:0] chk;
    logic [15:0] tag;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [15:0] wall;
    frame_result_t r;
    folded = {1'b0, rx_sum[15:0]} + {13'd0, rx_sum[19:16]};
    chk = ~folded[15:0];
    tag = {rx_store[2], rx_store[3]};
    w1 = {rx_store[7], rx_store[6], rx_store[5], rx_store[4]};
    w2 = {rx_store[11], rx_store[10], rx_store[9], rx_store[8]};
    wall = {rx_store[13], rx_store[12]};
    r = '0;
    if (chk != 16'd0) begin
      r.kind = KIND_CSUM_ERR;
      r.chk = chk;
      results_due.push_back(r);
    end else if (tag == cur_info_tag) begin
      r.kind = KIND_INFO;
      r.w1 = w1;
      results_due.push_back(r);
    end else if (tag == cur_measure_tag) begin
      if (!(cur_suppress && w1[30:0] == '0 && w2[30:0] == '0 && wall == '0)) begin
        r.kind = KIND_MEAS;
        r.w1 = w1;
        r.w2 = w2;
        r.wall = wall;
        results_due.push_back(r);
      end
    end else begin
      r.kind = KIND_UNKNOWN;
      results_due.push_back(r);
    end
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    case (rx_phase)
      PH_SECOND: begin
        if (b == cur_sync_second) begin
          rx_store[1] = b;
          rx_sum += {4'd0, b, 8'd0};
          rx_count = 4'd2;
          rx_phase = PH_GATHER;
        end else begin
          rx_phase = PH_HUNT;
          rx_count = '0;
        end
      end
      PH_GATHER: begin
        rx_store[rx_count] = b;
        rx_sum += rx_count[0] ? {4'd0, b, 8'd0} : {12'd0, b};
        if (rx_count == 4'(FRAME_BYTES - 1)) begin
          rx_phase = PH_HUNT;
          rx_count = '0;
          close_frame();
        end else begin
          rx_count++;
        end
      end
      default: begin
        rx_phase = PH_HUNT;
        if (b == cur_sync_first) begin
          rx_sum = {12'd0, b};
          rx_store[0] = b;
          rx_count = 4'd1;
          rx_phase = PH_SECOND;
        end
      end
    endcase
  endfunction

  // builds a frame whose last word makes the folded sum all ones
  function automatic frame_bytes_t make_frame(input shape_t shape);
    frame_bytes_t f;
    logic [19:0] s;
    logic [16:0] lo;
    logic [15:0] tag;
    int i;
    int j;
    for (i = 0; i < 16; i++) f[i] = 8'($urandom);
    f[0] = cur_sync_first;
    f[1] = cur_sync_second;
    tag = cur_info_tag;
    case (shape)
      SH_MEAS, SH_MAX, SH_EMPTY, SH_SIGN_ONLY: tag = cur_measure_tag;
      SH_UNKNOWN: begin
        do tag = 16'($urandom);
        while (tag == cur_info_tag || tag == cur_measure_tag);
      end
      default: ;
    endcase
    {f[2], f[3]} = tag;
    for (i = 4; i < 14; i++) begin
      if (shape == SH_MAX) f[i] = 8'hFF;
      else if (shape == SH_EMPTY || shape == SH_SIGN_ONLY) f[i] = 8'h00;
    end
    if (shape == SH_EMPTY) begin
      f[7][7] = 1'($urandom);
      f[11][7] = 1'($urandom);
    end
    if (shape == SH_SIGN_ONLY) begin
      f[7][7] = 1'b1;
      f[11][7] = 1'b1;
    end
    s = '0;
    for (i = 0; i < 7; i++) s += {4'd0, f[2*i+1], f[2*i]};
    lo = {1'b0, s[15:0]} + {13'd0, s[19:16]};
    {f[15], f[14]} = (lo <= 17'h0FFFF) ? 16'(17'h0FFFF - lo) : 16'(17'h1FFFE - lo);
    if (shape == SH_BAD_SUM) begin
      j = $urandom_range(15, 2);
      f[j] = f[j] ^ 8'(1 << $urandom_range(7));
    end
    return f;
  endfunction

  function automatic shape_t pick_shape();
    int r;
    r = $urandom_range(99);
    if (r < 28) return SH_INFO;
    if (r < 56) return SH_MEAS;
    if (r < 60) return SH_MAX;
    if (r < 66) return SH_EMPTY;
    if (r < 70) return SH_SIGN_ONLY;
    if (r < 78) return SH_UNKNOWN;
    if (r < 87) return SH_BAD_SUM;
    if (r < 92) return SH_BROKEN_SYNC;
    if (r < 95) return SH_RETRY_TRAP;
    return SH_NOISE;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_bytes_t f, input int first_idx, input int last_idx);
    int i;
    for (i = first_idx; i <= last_idx; i++) send_byte(f[i]);
  endtask

  task automatic send_shape(input shape_t shape);
    logic [7:0] b;
    int n;
    case (shape)
      SH_BROKEN_SYNC: begin
        send_byte(cur_sync_first);
        do b = 8'($urandom);
        while (b == cur_sync_second);
        send_byte(b);
      end
      SH_RETRY_TRAP: begin
        // the rejected second byte must not restart a frame
        send_byte(cur_sync_first);
        send_frame(make_frame(SH_INFO), 0, 15);
      end
      SH_NOISE: begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          b = 8'($urandom);
          if (b == cur_sync_first && $urandom_range(9) != 0) b = ~b;
          send_byte(b);
        end
      end
      default: send_frame(make_frame(shape), 0, 15);
    endcase
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SYNC_FIRST:     cur_sync_first = val[7:0];
      REG_SYNC_SECOND:    cur_sync_second = val[7:0];
      REG_INFO_TAG:       cur_info_tag = val;
      REG_MEASURE_TAG:    cur_measure_tag = val;
      REG_SUPPRESS_EMPTY: cur_suppress = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending, wait for every pending result and let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic restore_defaults();
    write_reg(REG_SYNC_FIRST, {8'd0, SYNC_FIRST_RST});
    write_reg(REG_SYNC_SECOND, {8'd0, SYNC_SECOND_RST});
    write_reg(REG_INFO_TAG, INFO_TAG_RST);
    write_reg(REG_MEASURE_TAG, MEASURE_TAG_RST);
    write_reg(REG_SUPPRESS_EMPTY, 16'd1);
  endtask

  task automatic test_reset_values();
    send_shape(SH_INFO);
    send_shape(SH_MEAS);
    send_shape(SH_MAX);
    send_shape(SH_EMPTY);
    send_shape(SH_SIGN_ONLY);
    send_shape(SH_UNKNOWN);
    send_shape(SH_BAD_SUM);
    send_shape(SH_BROKEN_SYNC);
    send_shape(SH_INFO);
    send_shape(SH_RETRY_TRAP);
    send_shape(SH_NOISE);
    send_shape(SH_MEAS);
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(REG_SYNC_FIRST, 16'h0000);
    write_reg(REG_SYNC_SECOND, 16'h00FF);
    write_reg(REG_INFO_TAG, 16'h0000);
    write_reg(REG_MEASURE_TAG, 16'hFFFF);
    write_reg(REG_SUPPRESS_EMPTY, 16'h0000);
    send_shape(SH_INFO);
    send_shape(SH_MEAS);
    send_shape(SH_EMPTY);
    send_shape(SH_SIGN_ONLY);
    send_shape(SH_UNKNOWN);
    send_shape(SH_BROKEN_SYNC);
    send_shape(SH_MAX);
    settle();
    // equal sync bytes, equal tags: info frame wins
    write_reg(REG_SYNC_FIRST, 16'h00FF);
    write_reg(REG_INFO_TAG, 16'hFFFF);
    write_reg(REG_SUPPRESS_EMPTY, 16'h0001);
    send_shape(SH_MEAS);
    send_shape(SH_EMPTY);
    send_shape(SH_BAD_SUM);
    send_shape(SH_BROKEN_SYNC);
    send_shape(SH_RETRY_TRAP);
    send_shape(SH_MEAS);
    settle();
    restore_defaults();
  endtask

  task automatic test_mid_frame_write();
    frame_bytes_t f;
    settle();
    f = make_frame(SH_MEAS);
    send_frame(f, 0, 7);
    settle();
    write_reg(REG_MEASURE_TAG, cur_measure_tag + 16'd1);
    send_frame(f, 8, 15);
    f = make_frame(SH_EMPTY);
    send_frame(f, 0, 9);
    settle();
    write_reg(REG_SUPPRESS_EMPTY, {15'd0, ~cur_suppress});
    send_frame(f, 10, 15);
    send_byte(cur_sync_first);
    settle();
    write_reg(REG_SYNC_SECOND, {8'd0, cur_sync_second ^ 8'h5A});
    f = make_frame(SH_INFO);
    send_frame(f, 1, 15);
    settle();
    restore_defaults();
  endtask

  task automatic test_backpressure();
    settle();
    hold_results <= 1'b1;
    fork
      begin
        repeat (150) @(negedge clk);
        hold_results <= 1'b0;
      end
    join_none
    repeat (6) send_shape(($urandom_range(1) != 0) ? SH_INFO : SH_MEAS);
    settle();
    repeat (4) send_shape(pick_shape());
    settle();
  endtask

  task automatic shuffle_registers();
    logic [15:0] tag;
    tag = 16'($urandom);
    if ($urandom_range(1) != 0) write_reg(REG_SYNC_FIRST, 16'($urandom_range(255)));
    if ($urandom_range(1) != 0) write_reg(REG_SYNC_SECOND, 16'($urandom_range(255)));
    if ($urandom_range(1) != 0) write_reg(REG_INFO_TAG, tag);
    if ($urandom_range(3) == 0) write_reg(REG_MEASURE_TAG, cur_info_tag);
    else if ($urandom_range(1) != 0) write_reg(REG_MEASURE_TAG, 16'($urandom));
    if ($urandom_range(1) != 0) write_reg(REG_SUPPRESS_EMPTY, 16'($urandom_range(1)));
  endtask

  // fills the run up to about TOTAL_BYTES byte transactions
  task automatic test_random_traffic();
    int round;
    int k;
    round = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      settle();
      if (round > 0) shuffle_registers();
      in_idle_pct  = (round == 2) ? 0 : 11;
      out_idle_pct = in_idle_pct;
      for (k = 0; k < 20 && bytes_sent < TOTAL_BYTES; k++) send_shape(pick_shape());
      round++;
    end
    in_idle_pct  = 11;
    out_idle_pct = 11;
  endtask

  always @(negedge clk) begin
    if (hold_results) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("kind %0d with no result pending", frame_kind));
      end else begin
        want = results_due.pop_front();
        if (frame_kind !== want.kind)
          report_mismatch($sformatf("frame_kind %0d, want %0d", frame_kind, want.kind));
        if (first_word !== want.w1)
          report_mismatch($sformatf("first_word %h, want %h", first_word, want.w1));
        if (second_word !== want.w2)
          report_mismatch($sformatf("second_word %h, want %h", second_word, want.w2));
        if (wall_distance !== want.wall)
          report_mismatch($sformatf("wall_distance %h, want %h", wall_distance, want.wall));
        if (check_value !== want.chk)
          report_mismatch($sformatf("check_value %h, want %h", check_value, want.chk));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_register_extremes();
    test_mid_frame_write();
    test_backpressure();
    test_random_traffic();
    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
sv/sfr_pkg.sv
sv/sfr_front.sv
sv/sfr_queue.sv
sv/sfr_back.sv
sv/sync_frame_receiver_with_checksum.sv
verif/tb.sv
